>>> hdl/kcl_pkg.sv
package kcl_pkg;

	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_PRESS   = 2'd1,
		MODE_RELEASE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_LOGIN  = 2'd1,
		PH_SELECT = 2'd2,
		PH_PARAM  = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		CMD_NONE          = 4'd0,
		CMD_OPEN          = 4'd1,
		CMD_ENROLL        = 4'd2,
		CMD_SET_OPEN_CODE = 4'd3,
		CMD_DELETE_USER   = 4'd4,
		CMD_DELETE_ALL    = 4'd5,
		CMD_SET_DELAY     = 4'd6,
		CMD_RESTORE       = 4'd7,
		CMD_SET_ADMIN     = 4'd8,
		CMD_CANCEL_ENROLL = 4'd9
	} cmd_t;

	localparam logic [3:0] FN_ENROLL     = 4'd1;
	localparam logic [3:0] FN_SET_CODE   = 4'd2;
	localparam logic [3:0] FN_DEL_USER   = 4'd3;
	localparam logic [3:0] FN_DEL_ALL    = 4'd4;
	localparam logic [3:0] FN_DELAY      = 4'd5;
	localparam logic [3:0] FN_RESTORE    = 4'd6;
	localparam logic [3:0] FN_SET_ADMIN  = 4'd9;

	localparam logic [3:0] DIGIT_POUND   = 4'd10;
	localparam int         BUF_DIGITS    = 6;
	localparam int         BUF_W         = 4 * BUF_DIGITS;
	localparam int         NUM_W         = 20;

	localparam logic [1:0] REG_OPEN_CODE = 2'd0;
	localparam logic [1:0] REG_ADMIN     = 2'd1;
	localparam logic [1:0] REG_TIMEOUT   = 2'd2;
	localparam logic [1:0] REG_LONG_PRESS = 2'd3;

	typedef struct packed {
		logic       hit;
		logic [3:0] digit;
	} key_t;

	typedef struct packed {
		cmd_t             command;
		logic [BUF_W-1:0] digits;
		logic [2:0]       count;
		phase_t           phase;
	} kcl_result_t;

	function automatic key_t map_key(logic [9:0] code);
		key_t k;
		k.hit = 1'b1;
		case (code)
			10'd115: k.digit = 4'd0;
			10'd114: k.digit = 4'd1;
			10'd139: k.digit = 4'd2;
			10'd128: k.digit = 4'd3;
			10'd28:  k.digit = 4'd4;
			10'd112: k.digit = 4'd5;
			10'd6:   k.digit = 4'd6;
			10'd7:   k.digit = 4'd7;
			10'd8:   k.digit = 4'd8;
			10'd9:   k.digit = 4'd9;
			10'd102: k.digit = DIGIT_POUND;
			default: begin
				k.hit   = 1'b0;
				k.digit = 4'd0;
			end
		endcase
		return k;
	endfunction

	function automatic logic [7:0] sat_inc(logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage

>>> hdl/kcl_core.sv
module kcl_core #(
	parameter int MAX_DIGITS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic                 advance,
	input  logic [1:0]           mode,
	input  logic [9:0]           key_code,
	input  logic [15:0]          open_code,
	input  logic [23:0]          admin_code,
	input  logic [7:0]           idle_timeout_s,
	input  logic [7:0]           long_press_s,
	output logic                 valid_s2,
	output kcl_pkg::kcl_result_t res_s2
);
	import kcl_pkg::*;

	localparam int CW = $clog2(MAX_DIGITS + 1);

	phase_t           phase_q, ph;
	logic [3:0]       func_q, fn;
	logic [BUF_W-1:0] ebuf_q, ebuf;
	logic [CW-1:0]    cnt_q, cnt;
	logic [7:0]       sec_q, sec;
	logic             pflag_q, pflag;
	logic [7:0]       psec_q, psec;
	kcl_result_t      res;
	key_t             key;
	logic             done;

	always_comb begin
		ph    = phase_q;
		fn    = func_q;
		ebuf  = ebuf_q;
		cnt   = cnt_q;
		sec   = sec_q;
		pflag = pflag_q;
		psec  = psec_q;
		done  = 1'b0;
		key   = map_key(key_code);
		res.command = CMD_NONE;
		res.digits  = '0;
		res.count   = '0;
		case (mode_t'(mode))
			MODE_TICK: begin
				sec = sat_inc(sec);
				if (pflag) begin
					psec = sat_inc(psec);
				end
				if (ph != PH_IDLE && sec > idle_timeout_s) begin
					ebuf = '0;
					cnt  = '0;
					ph   = PH_IDLE;
					fn   = '0;
				end
			end
			MODE_PRESS: begin
				if (key.hit) begin
					if (sec > idle_timeout_s) begin
						ebuf = '0;
						cnt  = '0;
						ph   = PH_IDLE;
					end
					sec = '0;
					if (ph == PH_SELECT) begin
						fn   = key.digit;
						ebuf = '0;
						cnt  = '0;
						ph   = PH_PARAM;
					end else if (cnt < CW'(MAX_DIGITS)) begin
						ebuf = {ebuf[BUF_W-5:0], key.digit};
						cnt  = cnt + CW'(1);
					end
					case (ph)
						PH_IDLE: begin
							if (cnt == CW'(4)) begin
								if (ebuf == {8'h00, open_code}) begin
									res.command = CMD_OPEN;
								end
								done = 1'b1;
							end
						end
						PH_LOGIN: begin
							if (cnt == CW'(6)) begin
								if (ebuf == admin_code) begin
									ph = PH_SELECT;
								end
								done = 1'b1;
							end
						end
						PH_PARAM: begin
							case (fn)
								FN_ENROLL: begin
									if (cnt == CW'(3)) begin
										res.command = CMD_ENROLL;
										done = 1'b1;
									end
								end
								FN_SET_CODE: begin
									if (cnt == CW'(4)) begin
										res.command = CMD_SET_OPEN_CODE;
										done = 1'b1;
									end
								end
								FN_DEL_USER: begin
									if (cnt == CW'(3)) begin
										res.command = CMD_DELETE_USER;
										done = 1'b1;
									end
								end
								FN_DEL_ALL: begin
									if (cnt == CW'(6)) begin
										if (ebuf == admin_code) begin
											res.command = CMD_DELETE_ALL;
										end
										done = 1'b1;
									end
								end
								FN_DELAY: begin
									if (cnt == CW'(2)) begin
										res.command = CMD_SET_DELAY;
										done = 1'b1;
									end
								end
								FN_RESTORE: begin
									if (cnt == CW'(6)) begin
										if (ebuf == admin_code) begin
											res.command = CMD_RESTORE;
										end
										done = 1'b1;
									end
								end
								FN_SET_ADMIN: begin
									if (cnt == CW'(6)) begin
										res.command = CMD_SET_ADMIN;
										done = 1'b1;
									end
								end
								default: ;
							endcase
						end
						default: ;
					endcase
					if (res.command != CMD_NONE) begin
						res.digits = ebuf;
						res.count  = (cnt > CW'(6)) ? 3'd6 : 3'(cnt);
					end
					if (done) begin
						ebuf = '0;
						cnt  = '0;
					end
					if (key.digit == DIGIT_POUND) begin
						pflag = 1'b1;
						psec  = '0;
					end
				end
			end
			MODE_RELEASE: begin
				if (key.hit && key.digit == DIGIT_POUND && pflag) begin
					if (ph != PH_IDLE) begin
						ph = PH_IDLE;
						if (fn == FN_ENROLL) begin
							res.command = CMD_CANCEL_ENROLL;
						end
					end else if (psec >= long_press_s) begin
						ph = PH_LOGIN;
					end
					ebuf  = '0;
					cnt   = '0;
					fn    = '0;
					pflag = 1'b0;
				end
			end
			default: ;
		endcase
		res.phase = ph;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			func_q   <= '0;
			ebuf_q   <= '0;
			cnt_q    <= '0;
			sec_q    <= 8'hFF;
			pflag_q  <= 1'b0;
			psec_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= ph;
				func_q  <= fn;
				ebuf_q  <= ebuf;
				cnt_q   <= cnt;
				sec_q   <= sec;
				pflag_q <= pflag;
				psec_q  <= psec;
			end
			if (!valid_s2 || advance) begin
				valid_s2 <= take;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s2 <= res;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_DIGITS))
		else $error("digit count beyond limit");

	a_select_empty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SELECT |-> cnt_q == '0 && ebuf_q == '0)
		else $error("function select with pending digits");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.command == CMD_NONE |-> res_s2.digits == '0 && res_s2.count == '0)
		else $error("no command but digits reported");

	a_open_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.command == CMD_OPEN |-> res_s2.phase == PH_IDLE)
		else $error("open command outside idle");
`endif

endmodule

>>> hdl/kcl_number.sv
module kcl_number (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 valid_s2,
	input  kcl_pkg::kcl_result_t res_s2,
	output logic                 out_valid,
	output logic [3:0]           command,
	output logic [23:0]          entered_digits,
	output logic [19:0]          entered_number,
	output logic [1:0]           phase
);
	import kcl_pkg::*;

	logic [BUF_W-1:0] aligned;
	logic [NUM_W-1:0] num;
	logic [3:0]       nib;
	logic             stop;

	always_comb begin
		aligned = res_s2.digits << {3'(3'd6 - res_s2.count), 2'b00};
		num     = '0;
		stop    = 1'b0;
		nib     = '0;
		for (int i = 0; i < BUF_DIGITS; i++) begin
			nib = aligned[BUF_W-1-4*i -: 4];
			if (3'(i) < res_s2.count && !stop) begin
				if (nib > 4'd9) begin
					stop = 1'b1;
				end else begin
					num = (num << 3) + (num << 1) + NUM_W'(nib);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			command        <= res_s2.command;
			entered_digits <= res_s2.digits;
			entered_number <= num;
			phase          <= res_s2.phase;
		end
	end

endmodule

>>> hdl/keypad_code_lock_controller.sv
// Keypad code lock controller. Each input transaction is a one-second tick,
// a key press or a key release, and every input transaction yields exactly one
// output transaction carrying the command (none, open, enroll, set code, ...),
// the digits that led to it, their decimal value and the phase after the
// event. An event enters an input register when it is accepted; when the
// core takes it, it updates the lock state and its result is registered,
// and the result then moves to the output register. One event is accepted
// every cycle while the output side keeps taking results. Registers sit on
// the APB port at byte addresses 0 (open code), 4 (admin code), 8 (idle timeout)
// and 12 (long press time) and may only be written while no transaction is in flight.
module keypad_code_lock_controller #(
	parameter int MAX_DIGITS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [9:0]  key_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  command,
	output logic [23:0] entered_digits,
	output logic [19:0] entered_number,
	output logic [1:0]  phase,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import kcl_pkg::*;

	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [9:0]  key_s1;
	logic        valid_s2;
	kcl_result_t res_s2;
	logic        advance;
	logic        s2_free;
	logic        take;
	logic        in_acc;
	logic [15:0] open_code_q;
	logic [23:0] admin_code_q;
	logic [7:0]  timeout_q;
	logic [7:0]  long_press_q;

	assign pready   = 1'b1;
	assign advance  = !out_valid || !out_stall;
	assign s2_free  = !valid_s2 || advance;
	assign take     = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !take);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_s1 <= mode;
			key_s1  <= key_code;
		end
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_code_q  <= '0;
			admin_code_q <= '0;
			timeout_q    <= 8'd10;
			long_press_q <= 8'd1;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_OPEN_CODE:  open_code_q  <= pwdata[15:0];
				REG_ADMIN:      admin_code_q <= pwdata[23:0];
				REG_TIMEOUT:    timeout_q    <= pwdata[7:0];
				REG_LONG_PRESS: long_press_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_OPEN_CODE:  prdata = {16'h0000, open_code_q};
			REG_ADMIN:      prdata = {8'h00, admin_code_q};
			REG_TIMEOUT:    prdata = {24'h000000, timeout_q};
			REG_LONG_PRESS: prdata = {24'h000000, long_press_q};
			default:        prdata = '0;
		endcase
	end

	kcl_core #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.advance       (advance),
		.mode          (mode_s1),
		.key_code      (key_s1),
		.open_code     (open_code_q),
		.admin_code    (admin_code_q),
		.idle_timeout_s(timeout_q),
		.long_press_s  (long_press_q),
		.valid_s2      (valid_s2),
		.res_s2        (res_s2)
	);

	kcl_number u_number (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.valid_s2      (valid_s2),
		.res_s2        (res_s2),
		.out_valid     (out_valid),
		.command       (command),
		.entered_digits(entered_digits),
		.entered_number(entered_number),
		.phase         (phase)
	);

endmodule

>>> tb/sv/lock_event_checker.sv
`timescale 1ns / 100ps

module lock_event_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [9:0]  key_code,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  command,
	input  logic [23:0] entered_digits,
	input  logic [19:0] entered_number,
	input  logic [1:0]  phase,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending,
	output int          checked,
	output int          cmd_count
);
	import kcl_pkg::*;

	typedef struct {
		cmd_t        cmd;
		logic [23:0] digits;
		logic [19:0] number;
		phase_t      ph;
	} lock_outcome_t;

	// register copies, snooped from the apb port
	logic [15:0] cfg_open;
	logic [23:0] cfg_admin;
	logic [7:0]  cfg_timeout;
	logic [7:0]  cfg_long;

	// predicted lock state
	phase_t      phase_q;
	logic [3:0]  fn_q;
	logic [23:0] buf_q;
	int          cnt_q;
	logic [7:0]  secs_q;
	logic        held_q;
	logic [7:0]  held_secs_q;

	lock_outcome_t outcome_q[$];
	lock_outcome_t fresh;
	lock_outcome_t want;

	function automatic logic [4:0] decode_key(logic [9:0] code);
		case (code)
			10'd115: return {1'b1, 4'd0};
			10'd114: return {1'b1, 4'd1};
			10'd139: return {1'b1, 4'd2};
			10'd128: return {1'b1, 4'd3};
			10'd28:  return {1'b1, 4'd4};
			10'd112: return {1'b1, 4'd5};
			10'd6:   return {1'b1, 4'd6};
			10'd7:   return {1'b1, 4'd7};
			10'd8:   return {1'b1, 4'd8};
			10'd9:   return {1'b1, 4'd9};
			10'd102: return {1'b1, DIGIT_POUND};
			default: return 5'd0;
		endcase
	endfunction

	// decimal value of the leading digits, stopping at the first pound
	function automatic logic [19:0] decimal_value(logic [23:0] nibs, int count);
		int n;
		logic [31:0] acc;
		logic [3:0] nib;
		n = (count > 6) ? 6 : count;
		acc = 0;
		for (int i = 0; i < n; i++) begin
			nib = nibs[4*(n-1-i) +: 4];
			if (nib > 4'd9)
				break;
			acc = acc * 10 + nib;
		end
		return acc[19:0];
	endfunction

	task automatic add_digit(input logic [3:0] d);
		if (cnt_q < 6) begin
			buf_q = {buf_q[19:0], d};
			cnt_q++;
		end
	endtask

	task automatic clear_buf();
		buf_q = '0;
		cnt_q = 0;
	endtask

	task automatic advance_lock(input logic [1:0] m, input logic [9:0] k,
			output lock_outcome_t o);
		logic [4:0] dk;
		logic [3:0] d;
		logic fin;
		cmd_t c;
		c = CMD_NONE;
		fin = 1'b0;
		o.digits = '0;
		o.number = '0;
		dk = decode_key(k);
		d = dk[3:0];
		case (m)
			MODE_TICK: begin
				if (secs_q != 8'hFF)
					secs_q++;
				if (held_q && held_secs_q != 8'hFF)
					held_secs_q++;
				if (phase_q != PH_IDLE && secs_q > cfg_timeout) begin
					clear_buf();
					phase_q = PH_IDLE;
					fn_q = '0;
				end
			end
			MODE_PRESS: if (dk[4]) begin
				if (secs_q > cfg_timeout) begin
					clear_buf();
					phase_q = PH_IDLE;
				end
				secs_q = '0;
				case (phase_q)
					PH_IDLE: begin
						add_digit(d);
						if (cnt_q == 4) begin
							if (buf_q == {8'h00, cfg_open})
								c = CMD_OPEN;
							fin = 1'b1;
						end
					end
					PH_LOGIN: begin
						add_digit(d);
						if (cnt_q == 6) begin
							if (buf_q == cfg_admin)
								phase_q = PH_SELECT;
							clear_buf();
						end
					end
					PH_SELECT: begin
						fn_q = d;
						clear_buf();
						phase_q = PH_PARAM;
					end
					default: begin
						add_digit(d);
						case (fn_q)
							FN_ENROLL: if (cnt_q == 3) begin
								c = CMD_ENROLL;
								fin = 1'b1;
							end
							FN_SET_CODE: if (cnt_q == 4) begin
								c = CMD_SET_OPEN_CODE;
								fin = 1'b1;
							end
							FN_DEL_USER: if (cnt_q == 3) begin
								c = CMD_DELETE_USER;
								fin = 1'b1;
							end
							FN_DEL_ALL: if (cnt_q == 6) begin
								if (buf_q == cfg_admin)
									c = CMD_DELETE_ALL;
								fin = 1'b1;
							end
							FN_DELAY: if (cnt_q == 2) begin
								c = CMD_SET_DELAY;
								fin = 1'b1;
							end
							FN_RESTORE: if (cnt_q == 6) begin
								if (buf_q == cfg_admin)
									c = CMD_RESTORE;
								fin = 1'b1;
							end
							FN_SET_ADMIN: if (cnt_q == 6) begin
								c = CMD_SET_ADMIN;
								fin = 1'b1;
							end
							default: ;
						endcase
					end
				endcase
				if (c != CMD_NONE) begin
					o.digits = buf_q;
					o.number = decimal_value(buf_q, cnt_q);
				end
				if (fin)
					clear_buf();
				if (d == DIGIT_POUND) begin
					held_q = 1'b1;
					held_secs_q = '0;
				end
			end
			MODE_RELEASE: if (dk[4] && d == DIGIT_POUND && held_q) begin
				if (phase_q != PH_IDLE) begin
					phase_q = PH_IDLE;
					if (fn_q == FN_ENROLL)
						c = CMD_CANCEL_ENROLL;
				end else if (held_secs_q >= cfg_long) begin
					phase_q = PH_LOGIN;
				end
				clear_buf();
				fn_q = '0;
				held_q = 1'b0;
			end
			default: ;
		endcase
		o.cmd = c;
		o.ph = phase_q;
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_v);
		errors++;
		$display("mismatch %0d at %0t: %s got %0h expected %0h",
			errors, $time, what, got, exp_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_open = '0;
			cfg_admin = '0;
			cfg_timeout = 8'd10;
			cfg_long = 8'd1;
			phase_q = PH_IDLE;
			fn_q = '0;
			clear_buf();
			secs_q = 8'hFF;
			held_q = 1'b0;
			held_secs_q = '0;
			outcome_q.delete();
			errors = 0;
			checked = 0;
			cmd_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_OPEN_CODE:  cfg_open = pwdata[15:0];
					REG_ADMIN:      cfg_admin = pwdata[23:0];
					REG_TIMEOUT:    cfg_timeout = pwdata[7:0];
					REG_LONG_PRESS: cfg_long = pwdata[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				advance_lock(mode, key_code, fresh);
				outcome_q.push_back(fresh);
			end
			if (out_valid && !out_stall) begin
				checked++;
				if (outcome_q.size() == 0) begin
					flag_mismatch("result with no transaction pending", command, 0);
				end else begin
					want = outcome_q.pop_front();
					if (want.cmd != CMD_NONE)
						cmd_count++;
					if (command !== want.cmd)
						flag_mismatch("command", command, want.cmd);
					if (entered_digits !== want.digits)
						flag_mismatch("entered_digits", entered_digits, want.digits);
					if (entered_number !== want.number)
						flag_mismatch("entered_number", entered_number, want.number);
					if (phase !== want.ph)
						flag_mismatch("phase", phase, want.ph);
				end
			end
		end
		pending = outcome_q.size();
	end

endmodule

>>> tb/sv/keypad_code_lock_controller_tb.sv
`timescale 1ns / 100ps

module keypad_code_lock_controller_tb;
	import kcl_pkg::*;

	localparam int EVENT_GOAL  = 1900;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = 2'd0;
	logic [9:0]  key_code = 10'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  command;
	logic [23:0] entered_digits;
	logic [19:0] entered_number;
	logic [1:0]  phase;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	int errors;
	int pending;
	int checked;
	int cmd_count;

	int cycle_count = 0;
	int events_sent = 0;
	int settings_used = 0;
	int stall_left = 0;
	int stall_draw;
	logic quiet = 1'b0;

	logic [15:0] cfg_open;
	logic [23:0] cfg_admin;
	int cfg_timeout;
	int cfg_long;

	logic [9:0] keypad_code [0:10] = '{10'd115, 10'd114, 10'd139, 10'd128, 10'd28,
		10'd112, 10'd6, 10'd7, 10'd8, 10'd9, 10'd102};
	logic [3:0] cmd_fn [0:6] = '{FN_ENROLL, FN_SET_CODE, FN_DEL_USER, FN_DEL_ALL,
		FN_DELAY, FN_RESTORE, FN_SET_ADMIN};

	keypad_code_lock_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.key_code(key_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.command(command),
		.entered_digits(entered_digits),
		.entered_number(entered_number),
		.phase(phase),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	lock_event_checker lock_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.key_code(key_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.command(command),
		.entered_digits(entered_digits),
		.entered_number(entered_number),
		.phase(phase),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.cmd_count(cmd_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run stopped at cycle limit with %0d results outstanding", pending);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side back-pressure, drawn per accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			stall_draw = quiet ? 0 : $urandom_range(0, 7);
			stall_left <= stall_draw;
			out_stall <= (stall_draw != 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= (stall_left > 1);
		end
	end

	function automatic logic [9:0] key_for(logic [3:0] nib);
		return (nib <= DIGIT_POUND) ? keypad_code[nib] : 10'd0;
	endfunction

	task automatic send_event(input logic [1:0] m, input logic [9:0] k);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		key_code <= k;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		events_sent++;
	endtask

	task automatic press(input logic [3:0] nib);
		send_event(MODE_PRESS, key_for(nib));
	endtask

	task automatic tick();
		send_event(MODE_TICK, 10'($urandom_range(0, 767)));
	endtask

	task automatic stray_tick();
		if ($urandom_range(0, 9) == 0)
			tick();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [15:0] o, input logic [23:0] a,
			input int t, input int l);
		drain();
		write_reg(REG_OPEN_CODE, {16'd0, o});
		write_reg(REG_ADMIN, {8'd0, a});
		write_reg(REG_TIMEOUT, 32'(t));
		write_reg(REG_LONG_PRESS, 32'(l));
		cfg_open = o;
		cfg_admin = a;
		cfg_timeout = t;
		cfg_long = l;
		settings_used++;
	endtask

	function automatic logic [23:0] random_code();
		logic [23:0] c;
		for (int i = 0; i < 6; i++)
			c[4*i +: 4] = ($urandom_range(0, 7) == 0) ? DIGIT_POUND : 4'($urandom_range(0, 9));
		return c;
	endfunction

	// empty the digit buffer and get back to idle
	task automatic flush_entry();
		if (cfg_long > 0) begin
			press(DIGIT_POUND);
			send_event(MODE_RELEASE, key_for(DIGIT_POUND));
		end else begin
			repeat (cfg_timeout + 1) tick();
		end
	endtask

	task automatic door_attempt();
		int bad;
		logic [3:0] nib;
		bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : -1;
		flush_entry();
		for (int i = 0; i < 4; i++) begin
			nib = cfg_open[15-4*i -: 4];
			if (i == bad)
				nib = 4'($urandom_range(0, 10));
			press(nib);
			if (nib != DIGIT_POUND && $urandom_range(0, 1) == 1)
				send_event(MODE_RELEASE, key_for(nib));
			stray_tick();
		end
	endtask

	task automatic admin_session();
		int bad, hold, r, n;
		logic [3:0] fn;
		logic [3:0] nib;
		flush_entry();
		press(DIGIT_POUND);
		hold = cfg_long;
		r = $urandom_range(0, 9);
		if (r == 0 && hold > 0)
			hold--;
		else if (r == 1)
			hold++;
		repeat (hold) tick();
		send_event(MODE_RELEASE, key_for(DIGIT_POUND));
		bad = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 5) : -1;
		for (int i = 0; i < 6; i++) begin
			nib = cfg_admin[23-4*i -: 4];
			if (i == bad)
				nib = 4'($urandom_range(0, 10));
			press(nib);
			stray_tick();
		end
		fn = ($urandom_range(0, 4) < 3) ? cmd_fn[$urandom_range(0, 6)]
			: 4'($urandom_range(0, 10));
		press(fn);
		repeat ($urandom_range(1, 2)) begin
			case (fn)
				FN_ENROLL, FN_DEL_USER: n = 3;
				FN_SET_CODE: n = 4;
				FN_DELAY: n = 2;
				FN_DEL_ALL, FN_RESTORE, FN_SET_ADMIN: n = 6;
				default: n = $urandom_range(0, 8);
			endcase
			if ($urandom_range(0, 3) == 0)
				n = $urandom_range(0, 8);
			for (int i = 0; i < n; i++) begin
				if ((fn == FN_DEL_ALL || fn == FN_RESTORE) && i < 6
						&& $urandom_range(0, 3) != 0)
					nib = cfg_admin[23-4*i -: 4];
				else
					nib = ($urandom_range(0, 9) == 0) ? DIGIT_POUND
						: 4'($urandom_range(0, 9));
				press(nib);
				stray_tick();
			end
		end
		if (cfg_timeout <= 12 && $urandom_range(0, 9) < 3) begin
			repeat (cfg_timeout + 1) tick();
		end else begin
			press(DIGIT_POUND);
			send_event(MODE_RELEASE, key_for(DIGIT_POUND));
		end
	endtask

	task automatic noise_burst();
		int r;
		logic [1:0] m;
		repeat ($urandom_range(1, 6)) begin
			r = $urandom_range(0, 15);
			m = (r == 0) ? 2'd3 : 2'(r % 3);
			send_event(m, ($urandom_range(0, 1) == 1) ? keypad_code[$urandom_range(0, 10)]
				: 10'($urandom_range(0, 767)));
		end
	endtask

	initial begin
		int goal;
		int r;
		logic [23:0] rnd_code;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored codes, door open, login, enroll and its cancel
		apply_settings(16'h2580, 24'h135790, 5, 1);
		send_event(MODE_TICK, 10'd767);
		send_event(MODE_PRESS, 10'd0);
		send_event(MODE_PRESS, 10'd767);
		send_event(2'd3, keypad_code[DIGIT_POUND]);
		for (int i = 0; i < 4; i++)
			press(cfg_open[15-4*i -: 4]);
		send_event(MODE_RELEASE, keypad_code[2]);
		send_event(MODE_RELEASE, keypad_code[DIGIT_POUND]);
		press(DIGIT_POUND);
		tick();
		send_event(MODE_RELEASE, keypad_code[DIGIT_POUND]);
		for (int i = 0; i < 6; i++)
			press(cfg_admin[23-4*i -: 4]);
		press(FN_ENROLL);
		press(4'd4);
		press(DIGIT_POUND);
		send_event(MODE_RELEASE, keypad_code[DIGIT_POUND]);

		for (int ph = 1; events_sent < EVENT_GOAL; ph++) begin
			if (ph == 1) begin
				apply_settings(16'h0000, 24'h000000, 1, 0);
			end else if (ph == 2) begin
				apply_settings(16'hFFFF, 24'hFFFFFF, 254, 254);
			end else begin
				r = $urandom_range(1, 12);
				rnd_code = random_code();
				apply_settings(rnd_code[15:0], random_code(), r,
					$urandom_range(1, (r < 3) ? r : 3));
			end
			goal = events_sent + ((ph == 2) ? 300 : 260);
			while (events_sent < goal) begin
				if ($urandom_range(0, 7) == 0)
					quiet = ~quiet;
				r = $urandom_range(0, 9);
				if (r < 3)
					door_attempt();
				else if (r < 7)
					admin_session();
				else
					noise_burst();
			end
		end
		drain();

		$display("%0d transactions checked over %0d register settings, %0d with a lock command",
			checked, settings_used, cmd_count);
		if (errors == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> keypad_code_lock_controller.f
hdl/kcl_pkg.sv
hdl/kcl_core.sv
hdl/kcl_number.sv
hdl/keypad_code_lock_controller.sv
tb/sv/lock_event_checker.sv
tb/sv/keypad_code_lock_controller_tb.sv
